[sv/i2cm_pkg.sv]
// Package: shared types, constants and codes of the I2C master byte engine.
package i2cm_pkg;

  // Tick counter width and derived widths
  localparam int unsigned TICK_W = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned LEN_W = ((CFG_W + 1 > TICK_W) ? CFG_W + 1 : TICK_W) + 1;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam int unsigned POST_ACK_TICKS = 100;

  localparam logic [CFG_W-1:0] CFG_RESET_TICKS = CFG_W'(8);

  // Command codes
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_LOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_START_HOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_STOP_HOLD = CFG_IDX_W'(3);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ST_HIGH  = 4'd1,
    PH_ST_HOLD  = 4'd2,
    PH_ST_LOW   = 4'd3,
    PH_SP_LOW   = 4'd4,
    PH_SP_HIGH  = 4'd5,
    PH_SP_HOLD  = 4'd6,
    PH_WR_LEAD  = 4'd7,
    PH_WR_HIGH  = 4'd8,
    PH_WR_TRAIL = 4'd9,
    PH_RD_LEAD  = 4'd10,
    PH_RD_HIGH  = 4'd11,
    PH_RD_TRAIL = 4'd12,
    PH_RD_POST  = 4'd13
  } phase_e;

  typedef struct packed {
    logic [CFG_W-1:0] clock_low_ticks;
    logic [CFG_W-1:0] clock_high_ticks;
    logic [CFG_W-1:0] start_hold_ticks;
    logic [CFG_W-1:0] stop_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       rejected;
  } res_item_t;

endpackage

[sv/i2cm_if.sv]
// Interfaces: command, result and configuration channels of the I2C master engine.
interface i2cm_cmd_if;
  import i2cm_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       sda_sample;
  modport source (output valid, command, tx_byte, sda_sample, input ready);
  modport sink (input valid, command, tx_byte, sda_sample, output ready);
endinterface

interface i2cm_res_if;
  import i2cm_pkg::*;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       rejected;
  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_seen, rejected, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                rx_byte, ack_seen, rejected, output ready);
endinterface

interface i2cm_cfg_if;
  import i2cm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/i2c_master_byte_engine.sv]
// Top level: I2C master byte engine with input register, sequencer and result register.
// One command item is one bus tick; the engine takes one item per clock cycle and returns
// exactly one result item for each, passing through the item register and then the
// sequencer's combinational update into the result register. Throughput is limited only by
// the result channel: a stalled result holds the pipeline, a free one lets an item enter
// every cycle. Timing registers give SCL low, SCL high, start hold and stop hold in ticks;
// zero lengths count as one tick and lengths saturate at the 16-bit tick counter maximum.
// Commands issued while a sequence runs are ignored and flagged as rejected.
module i2c_master_byte_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2cm_cmd_if.sink  cmd_if,
  i2cm_res_if.source res_if,
  i2cm_cfg_if.sink  cfg_if
);
  import i2cm_pkg::*;

  cfg_t      cfg;
  cmd_item_t in_q;
  logic      in_valid_q;
  res_item_t res_d, res_q;
  logic      out_valid_q;
  logic      adv, step;

  // Pipeline moves when the result register is free or being drained
  assign adv  = !out_valid_q || res_if.ready;
  assign step = in_valid_q && adv;
  assign cmd_if.ready = !in_valid_q || adv;

  i2cm_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  i2cm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Input item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_if.ready) begin
      in_valid_q <= cmd_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_if.ready && cmd_if.valid) begin
      in_q <= '{cmd_if.command, cmd_if.tx_byte, cmd_if.sda_sample};
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_if.valid     = out_valid_q;
  assign res_if.scl_level = res_q.scl_level;
  assign res_if.sda_level = res_q.sda_level;
  assign res_if.sda_drive = res_q.sda_drive;
  assign res_if.busy_res  = res_q.busy_res;
  assign res_if.done_res  = res_q.done_res;
  assign res_if.rx_byte   = res_q.rx_byte;
  assign res_if.ack_seen  = res_q.ack_seen;
  assign res_if.rejected  = res_q.rejected;

endmodule

[sv/i2cm_cfg_regs.sv]
// Configuration register file: bus timing values in ticks.
module i2cm_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  i2cm_cfg_if.sink       cfg_if,
  output i2cm_pkg::cfg_t cfg_o
);
  import i2cm_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_if.ready = 1'b1;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_CLOCK_LOW:  cfg_d.clock_low_ticks = cfg_if.data;
        REG_CLOCK_HIGH: cfg_d.clock_high_ticks = cfg_if.data;
        REG_START_HOLD: cfg_d.start_hold_ticks = cfg_if.data;
        REG_STOP_HOLD:  cfg_d.stop_hold_ticks = cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{CFG_RESET_TICKS, CFG_RESET_TICKS, CFG_RESET_TICKS, CFG_RESET_TICKS};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/i2cm_core.sv]
// Bus sequencer: per-tick phase, counter, shifter and pin state update.
module i2cm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2cm_pkg::cmd_item_t item_i,
  input  i2cm_pkg::cfg_t      cfg_i,
  output i2cm_pkg::res_item_t res_o
);
  import i2cm_pkg::*;

  localparam logic [LEN_W-1:0] CNT_MAX = LEN_W'({TICK_W{1'b1}});

  phase_e            phase_q, phase_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [3:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic [7:0]        rx_hold_q, rx_hold_d;
  logic              ack_q, ack_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              oe_q, oe_d;
  logic              done, rej;
  logic [LEN_W-1:0]  len;

  // Length of a phase in ticks, clamped to 1 .. counter maximum
  function automatic logic [LEN_W-1:0] phase_len(phase_e ph, cfg_t c);
    logic [LEN_W-1:0] d;
    unique case (ph)
      PH_ST_HIGH, PH_WR_HIGH, PH_RD_HIGH: d = LEN_W'(c.clock_high_ticks);
      PH_ST_HOLD:  d = LEN_W'(c.start_hold_ticks);
      PH_ST_LOW:   d = LEN_W'(c.clock_low_ticks);
      PH_SP_LOW:   d = LEN_W'(c.clock_low_ticks) << 1;
      PH_SP_HIGH:  d = LEN_W'(c.clock_high_ticks) << 1;
      PH_SP_HOLD:  d = LEN_W'(c.stop_hold_ticks);
      PH_RD_POST:  d = LEN_W'(POST_ACK_TICKS);
      default:     d = LEN_W'(c.clock_low_ticks >> 1);
    endcase
    if (d == '0) d = LEN_W'(1);
    if (d > CNT_MAX) d = CNT_MAX;
    return d;
  endfunction

  // Next state for one tick
  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    rx_hold_d = rx_hold_q;
    ack_d     = ack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    oe_d      = oe_q;
    done      = 1'b0;
    rej       = 1'b0;
    len       = '0;

    // Command launch or reject
    if (item_i.command == CMD_START || item_i.command == CMD_STOP ||
        item_i.command == CMD_WRITE || item_i.command == CMD_READ) begin
      if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tick_d = '0;
        bit_d  = '0;
        unique case (item_i.command)
          CMD_START: begin
            oe_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1; phase_d = PH_ST_HIGH;
          end
          CMD_STOP: begin
            oe_d = 1'b1; sda_d = 1'b0; scl_d = 1'b0; phase_d = PH_SP_LOW;
          end
          CMD_WRITE: begin
            shift_d = item_i.tx_byte;
            oe_d = 1'b1; scl_d = 1'b0;
            sda_d = |(item_i.tx_byte & MSB_MASK);
            phase_d = PH_WR_LEAD;
          end
          default: begin
            shift_d = '0;
            oe_d = 1'b0; scl_d = 1'b0; phase_d = PH_RD_LEAD;
          end
        endcase
      end
    end

    // Tick count and phase advance
    if (phase_d != PH_IDLE) begin
      tick_d = tick_d + TICK_W'(1);
      len = phase_len(phase_d, cfg_i);
      if (LEN_W'(tick_d) >= len) begin
        tick_d = '0;
        unique case (phase_d)
          PH_ST_HIGH: begin phase_d = PH_ST_HOLD; sda_d = 1'b0; end
          PH_ST_HOLD: begin phase_d = PH_ST_LOW; scl_d = 1'b0; end
          PH_ST_LOW:  begin phase_d = PH_IDLE; done = 1'b1; end
          PH_SP_LOW:  begin phase_d = PH_SP_HIGH; scl_d = 1'b1; end
          PH_SP_HIGH: begin phase_d = PH_SP_HOLD; sda_d = 1'b1; end
          PH_SP_HOLD: begin phase_d = PH_IDLE; oe_d = 1'b0; done = 1'b1; end
          PH_WR_LEAD: begin
            phase_d = PH_WR_HIGH; scl_d = 1'b1;
            if (bit_d >= BITS_PER_BYTE) oe_d = 1'b0;
          end
          PH_WR_HIGH: begin
            scl_d = 1'b0;
            if (bit_d >= BITS_PER_BYTE) begin
              // acknowledge clock: sample and go back to driving low
              ack_d = ~item_i.sda_sample;
              oe_d = 1'b1;
              phase_d = PH_IDLE;
              done = 1'b1;
            end else begin
              phase_d = PH_WR_TRAIL;
            end
          end
          PH_WR_TRAIL: begin
            shift_d = shift_d << 1;
            bit_d = bit_d + 4'd1;
            sda_d = (bit_d >= BITS_PER_BYTE) ? 1'b0 : |(shift_d & MSB_MASK);
            phase_d = PH_WR_LEAD;
          end
          PH_RD_LEAD: begin phase_d = PH_RD_HIGH; scl_d = 1'b1; end
          PH_RD_HIGH: begin
            if (bit_d < BITS_PER_BYTE) shift_d = {shift_d[6:0], item_i.sda_sample};
            scl_d = 1'b0;
            phase_d = PH_RD_TRAIL;
          end
          PH_RD_TRAIL: begin
            if (bit_d >= BITS_PER_BYTE) begin
              phase_d = PH_RD_POST;
            end else begin
              bit_d = bit_d + 4'd1;
              // last data bit done: drive the master ACK
              if (bit_d >= BITS_PER_BYTE) begin
                sda_d = 1'b0; oe_d = 1'b1;
              end
              phase_d = PH_RD_LEAD;
            end
          end
          PH_RD_POST: begin rx_hold_d = shift_d; phase_d = PH_IDLE; done = 1'b1; end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // State registers, updated once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      bit_q     <= '0;
      shift_q   <= '0;
      rx_hold_q <= '0;
      ack_q     <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      oe_q      <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      rx_hold_q <= rx_hold_d;
      ack_q     <= ack_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      oe_q      <= oe_d;
    end
  end

  // Result of this tick
  always_comb begin
    res_o.scl_level = scl_d;
    res_o.sda_level = sda_d;
    res_o.sda_drive = oe_d;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.rx_byte   = rx_hold_d;
    res_o.ack_seen  = ack_d;
    res_o.rejected  = rej;
  end

`ifndef NO_ASSERTIONS
  // a sequence can only finish from a running phase
  a_done_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |-> phase_q != PH_IDLE)
    else $error("done without a running sequence");

  // bit counter never runs past the acknowledge slot
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= BITS_PER_BYTE)
    else $error("bit index out of range");

  // idle always leaves the tick counter cleared
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> tick_q == '0)
    else $error("tick counter not cleared in idle");

  // SDA is released while the slave drives the write ACK
  a_ack_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WR_HIGH && bit_q >= BITS_PER_BYTE |-> !oe_q)
    else $error("SDA driven during write acknowledge");
`endif

endmodule
